FILE: rtl/mhfp_pkg.sv
// ----------------------------------------------------------------------------
// mhfp_pkg
// Shared types and constants of the mail header fold parser.
// ----------------------------------------------------------------------------
package mhfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 16;
    localparam int CLASS_W  = 3;
    localparam int PHASE_W  = 3;
    localparam int STATUS_W = 2;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    localparam logic [CLASS_W-1:0] CL_OTHER = 3'd0;
    localparam logic [CLASS_W-1:0] CL_WSP   = 3'd1;
    localparam logic [CLASS_W-1:0] CL_LF    = 3'd2;
    localparam logic [CLASS_W-1:0] CL_CR    = 3'd3;
    localparam logic [CLASS_W-1:0] CL_COLON = 3'd4;

    localparam logic [PHASE_W-1:0] PH_LINE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_NAME  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_FOLD  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_VLEAD = 3'd3;
    localparam logic [PHASE_W-1:0] PH_VAL   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_VCR   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_FIN   = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVR  = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [CLASS_W-1:0] cls;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                commit;
        logic                named;
        logic                fold;
        logic                cvalid;
        logic                cisval;
        logic [BYTE_W-1:0]   chr;
    } t_result;

endpackage

FILE: rtl/mhfp_front.sv
// ----------------------------------------------------------------------------
// mhfp_front
// Input stage: registers each accepted byte together with its character class.
// ----------------------------------------------------------------------------
module mhfp_front
    import mhfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_push,
    output t_item             o_item,
    input  logic              i_q_full
);

    logic              r_valid;
    logic              n_valid;
    t_item             r_item;
    logic [CLASS_W-1:0] w_cls;
    logic              w_take;

    always_comb begin
        if (i_in_byte == CH_TAB || i_in_byte == CH_SP) begin
            w_cls = CL_WSP;
        end else if (i_in_byte == CH_LF) begin
            w_cls = CL_LF;
        end else if (i_in_byte == CH_CR) begin
            w_cls = CL_CR;
        end else if (i_in_byte == CH_COLON) begin
            w_cls = CL_COLON;
        end else begin
            w_cls = CL_OTHER;
        end
    end

    assign o_push     = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign w_take     = i_in_valid && !o_in_stall;
    assign n_valid    = w_take || (r_valid && i_q_full);
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.data <= i_in_byte;
            r_item.cls  <= w_cls;
        end
    end

endmodule

FILE: rtl/mhfp_queue.sv
// ----------------------------------------------------------------------------
// mhfp_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module mhfp_queue
    import mhfp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_nonempty,
    output t_item o_item
);

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic [QPTR_W-1:0]  n_wr;
    logic [QPTR_W-1:0]  n_rd;
    logic [QCNT_W-1:0]  n_cnt;

    localparam logic [QPTR_W-1:0] LAST = QPTR_W'(QDEPTH - 1);

    assign o_full     = (r_cnt == QCNT_W'(QDEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_item     = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: rtl/mhfp_back.sv
// ----------------------------------------------------------------------------
// mhfp_back
// Parse phase machine, byte counter, limit register and result register.
// ----------------------------------------------------------------------------
module mhfp_back
    import mhfp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    input  logic               i_q_nonempty,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_result            o_result
);

    localparam int EXT_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic [LIMIT_W-1:0]     r_limit;
    logic [PHASE_W-1:0]     r_phase;
    logic [PHASE_W-1:0]     n_phase;
    logic                   r_open;
    logic                   n_open;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   r_out_valid;
    t_result                r_result;
    t_result                w_res;
    logic                   w_load;
    logic                   w_over;
    logic                   w_count;
    logic                   w_name_path;
    logic                   w_wsp;

    assign w_load      = !r_out_valid || !i_out_stall;
    assign o_pop       = i_q_nonempty && w_load;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign w_over      = EXT_W'(r_count) >= EXT_W'(r_limit);
    assign w_wsp       = (i_item.cls == CL_WSP);

    always_comb begin
        n_phase     = r_phase;
        n_open      = r_open;
        w_count     = 1'b0;
        w_name_path = 1'b0;
        w_res       = '0;
        case (r_phase)
            PH_LINE, PH_NAME: begin
                if (r_phase == PH_NAME) begin
                    w_name_path = 1'b1;
                end else if (w_wsp) begin
                    if (!r_open) begin
                        w_res.status = ST_ERR;
                    end else begin
                        w_res.fold = 1'b1;
                        w_count    = 1'b1;
                        if (w_over) begin
                            w_res.status = ST_OVR;
                        end else begin
                            w_res.cvalid = 1'b1;
                            w_res.cisval = 1'b1;
                            n_phase      = PH_FOLD;
                        end
                    end
                end else begin
                    if (r_open) begin
                        w_res.commit = 1'b1;
                        n_open       = 1'b0;
                    end
                    if (i_item.cls == CL_LF) begin
                        w_res.status = ST_DONE;
                    end else if (i_item.cls == CL_CR) begin
                        n_phase = PH_FIN;
                    end else begin
                        w_name_path = 1'b1;
                    end
                end
                if (w_name_path) begin
                    if (i_item.cls == CL_COLON) begin
                        w_res.named = 1'b1;
                        n_open      = 1'b1;
                        n_phase     = PH_VLEAD;
                    end else begin
                        w_count = 1'b1;
                        if (w_over) begin
                            w_res.status = ST_OVR;
                        end else begin
                            w_res.cvalid = 1'b1;
                            n_phase      = PH_NAME;
                        end
                    end
                end
            end
            PH_FOLD, PH_VLEAD, PH_VAL: begin
                if (r_phase == PH_FOLD && w_wsp) begin
                    w_res.cvalid = 1'b1;
                    w_res.cisval = 1'b1;
                end else if (r_phase != PH_VAL && w_wsp) begin
                    n_phase = r_phase;
                end else if (i_item.cls == CL_LF) begin
                    n_phase = PH_LINE;
                end else if (i_item.cls == CL_CR) begin
                    n_phase = PH_VCR;
                end else begin
                    w_count = 1'b1;
                    if (w_over) begin
                        w_res.status = ST_OVR;
                    end else begin
                        w_res.cvalid = 1'b1;
                        w_res.cisval = 1'b1;
                        n_phase      = PH_VAL;
                    end
                end
            end
            PH_VCR: begin
                if (i_item.cls != CL_LF) begin
                    w_res.status = ST_ERR;
                end else begin
                    n_phase = PH_LINE;
                end
            end
            PH_FIN: begin
                w_res.status = (i_item.cls == CL_LF) ? ST_DONE : ST_ERR;
            end
            default: begin
                w_res.status = ST_ERR;
            end
        endcase
        if (w_res.cvalid) begin
            w_res.chr = i_item.data;
        end
        n_count = r_count;
        if (w_count && (r_count != '1)) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_phase     <= PH_LINE;
            r_open      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (o_pop) begin
                r_phase <= n_phase;
                r_open  <= n_open;
                r_count <= n_count;
            end
            if (w_load) begin
                r_out_valid <= i_q_nonempty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= w_res;
        end
    end

endmodule

FILE: rtl/mail_header_fold_parser.sv
// ----------------------------------------------------------------------------
// mail_header_fold_parser
// Byte-serial parser of a mail header block with continuation folding.
// ----------------------------------------------------------------------------
// Path: each accepted byte passes through the input register, a queue entry
// and the result register before its result is valid.
// Throughput: one byte per cycle while i_out_stall is low.
// Reset clears the phase, open-header flag, byte counter, queue and valids;
// the limit register resets to 65535.
module mail_header_fold_parser
    import mhfp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [LIMIT_W-1:0]  i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [BYTE_W-1:0]   i_in_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_value_commit,
    output logic                o_name_done,
    output logic                o_fold_mark,
    output logic                o_char_valid,
    output logic                o_char_is_value,
    output logic [BYTE_W-1:0]   o_char_out
);

    t_item   w_front_item;
    t_item   w_q_item;
    t_result w_result;
    logic    w_push;
    logic    w_full;
    logic    w_pop;
    logic    w_nonempty;

    assign o_cfg_ready = 1'b1;

    mhfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_byte  (i_in_byte),
        .o_push     (w_push),
        .o_item     (w_front_item),
        .i_q_full   (w_full)
    );

    mhfp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_item     (w_front_item),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_item     (w_q_item)
    );

    mhfp_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_q_nonempty (w_nonempty),
        .i_item       (w_q_item),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result     (w_result)
    );

    assign o_status        = w_result.status;
    assign o_value_commit  = w_result.commit;
    assign o_name_done     = w_result.named;
    assign o_fold_mark     = w_result.fold;
    assign o_char_valid    = w_result.cvalid;
    assign o_char_is_value = w_result.cisval;
    assign o_char_out      = w_result.chr;

endmodule
